// File: rtl/mia_pkg.sv
// Shared types and constants for the multiword integer ALU.
`default_nettype none
package mia_pkg;

    // Operation codes of the configuration register.
    localparam int OP_W = 2;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    // Port word width and widths that cover the whole limb count range.
    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;
    localparam int ADDR_W = 6;

    // One run handed from the front end to the execution unit.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        op_t              op;
        logic             ovf;
        logic             zdiv;
    } job_t;

    // Operand store write from the front end.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } opw_t;

endpackage
`default_nettype wire

// File: rtl/mia_front.sv
// Input front end: takes limb pairs, counts them and issues one job per run.
`default_nettype none
module mia_front #(
    parameter int MAX_LIMBS = 64,
    parameter int LIMB_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire mia_pkg::op_t             cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [mia_pkg::WORD_W-1:0] a_limb,
    input  wire logic [mia_pkg::WORD_W-1:0] b_limb,
    input  wire logic                     last_limb,
    input  wire logic                     hold,
    output logic                          push,
    output mia_pkg::job_t                 job,
    output mia_pkg::opw_t                 opw
);
    localparam int NW = $clog2(MAX_LIMBS + 1);
    localparam int AW = mia_pkg::ADDR_W;
    localparam int CW = mia_pkg::CNT_W;
    localparam logic [31:0] LIMB_MASK = 32'((64'd1 << LIMB_BITS) - 64'd1);

    mia_pkg::op_t    op_reg;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            bnz_reg, bnz_next;
    logic            accept, room;
    logic [31:0]     a_m, b_m;
    logic [NW:0]     cnt_inc;

    assign in_stall = hold;
    assign accept   = in_valid && !in_stall;
    assign room     = cnt_reg < NW'(MAX_LIMBS);
    assign a_m      = a_limb & LIMB_MASK;
    assign b_m      = b_limb & LIMB_MASK;
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;

    assign opw.we   = accept && room;
    assign opw.addr = AW'(cnt_reg);
    assign opw.a    = a_m;
    assign opw.b    = b_m;

    assign push     = accept && last_limb;
    assign job.cnt  = room ? CW'(cnt_inc) : CW'(cnt_reg);
    assign job.op   = op_reg;
    assign job.ovf  = ovf_reg || !room;
    assign job.zdiv = (op_reg == mia_pkg::OP_DIV) && !(bnz_reg || (room && b_m != 32'd0));

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        bnz_next = bnz_reg;
        if (accept)
        begin
            if (last_limb)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
                bnz_next = 1'b0;
            end
            else if (room)
            begin
                cnt_next = NW'(cnt_inc);
                bnz_next = bnz_reg || (b_m != 32'd0);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= mia_pkg::OP_ADD;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            bnz_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                op_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            bnz_reg <= bnz_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/mia_queue.sv
// Two-entry job queue between the front end and the execution unit.
`default_nettype none
module mia_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mia_pkg::job_t din,
    input  wire logic          pop,
    output mia_pkg::job_t      dout,
    output logic               nonempty
);
    mia_pkg::job_t slot_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          do_push, do_pop;

    assign do_push  = push && (cnt_reg != 2'd2);
    assign do_pop   = pop && (cnt_reg != 2'd0);
    assign nonempty = cnt_reg != 2'd0;
    assign dout     = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule
`default_nettype wire

// File: rtl/mia_back.sv
// Execution unit: operand and work memories, limb sequencer and output register.
`default_nettype none
module mia_back #(
    parameter int MAX_LIMBS = 64,
    parameter int LIMB_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       job_valid,
    input  wire mia_pkg::job_t              job,
    output logic                            pop,
    output logic                            busy,
    input  wire mia_pkg::opw_t              opw,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [mia_pkg::WORD_W-1:0]      low_word,
    output logic [mia_pkg::WORD_W-1:0]      high_word,
    output logic                            carry_flag,
    output logic                            zero_divisor,
    output logic                            too_long,
    output logic                            final_result
);
    localparam int L  = LIMB_BITS;
    localparam int NW = $clog2(MAX_LIMBS + 1);
    localparam int AW = $clog2(MAX_LIMBS);
    localparam int WA = $clog2(2 * MAX_LIMBS);
    localparam int RA = $clog2(MAX_LIMBS + 1);
    localparam int BW = $clog2(LIMB_BITS);
    localparam int XW = WA + 1;
    localparam int OW = mia_pkg::WORD_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_MRD  = 4'd2;
    localparam logic [3:0] S_MMUL = 4'd3;
    localparam logic [3:0] S_MACC = 4'd4;
    localparam logic [3:0] S_MTOP = 4'd5;
    localparam logic [3:0] S_DA   = 4'd6;
    localparam logic [3:0] S_DAL  = 4'd7;
    localparam logic [3:0] S_DP   = 4'd8;
    localparam logic [3:0] S_DL   = 4'd9;
    localparam logic [3:0] S_DE   = 4'd10;
    localparam logic [3:0] S_ORD  = 4'd11;
    localparam logic [3:0] S_OWR  = 4'd12;

    // Memories
    logic [L-1:0] a_mem  [MAX_LIMBS];
    logic [L-1:0] b_mem  [MAX_LIMBS];
    logic [L-1:0] w_mem  [2*MAX_LIMBS];
    logic [L-1:0] r0_mem [MAX_LIMBS+1];
    logic [L-1:0] r1_mem [MAX_LIMBS+1];
    logic [L-1:0] a_rd, b_rd, w_rd0, w_rd1, r0_rd, r1_rd;

    logic [AW-1:0] a_ra, b_ra;
    logic [WA-1:0] w_ra0, w_ra1, w_wa;
    logic [RA-1:0] r_ra, r_wa;
    logic          w_we, r0_we, r1_we;
    logic [L-1:0]  w_wd, r0_wd, r1_wd;

    // Control and datapath registers
    logic [3:0]      state_reg, state_next;
    logic [NW-1:0]   n_reg, n_next, k_reg, k_next, i_reg, i_next;
    logic [NW-1:0]   j_reg, j_next, pi_reg, pi_next;
    mia_pkg::op_t    op_reg, op_next;
    logic            ovf_reg, ovf_next, zdiv_reg, zdiv_next;
    logic [WA-1:0]   cw_reg, cw_next;
    logic            cy_reg, cy_next;
    logic [L-1:0]    mc_reg, mc_next, wh_reg, wh_next;
    logic [2*L-1:0]  prod_reg, prod_next;
    logic [AW-1:0]   li_reg, li_next;
    logic [BW-1:0]   bi_reg, bi_next;
    logic            sh_reg, sh_next, dbw_reg, dbw_next, cur_reg, cur_next;
    logic [L-1:0]    q_reg, q_next, dv_reg, dv_next;
    logic            ov_reg, ov_next;
    logic [OW-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic            cf_reg, cf_next, zd_reg, zd_next, tl_reg, tl_next;
    logic            fr_reg, fr_next;

    // Combinational helpers
    logic            out_free, last_k;
    logic [XW-1:0]   cw_x, n_x;
    logic [NW:0]     j_inc, i_inc, k_inc, pi_inc;
    logic [NW:0]     ij_sum;
    logic [2*L-1:0]  acc;
    logic [L:0]      add_t, sub_y, dd;
    logic [L-1:0]    r_cur, b_val, s_val, q_new;
    logic            q_bit;

    assign out_free = !ov_reg || !out_stall;
    assign busy     = state_reg != S_IDLE;
    assign cw_x     = XW'(cw_reg);
    assign n_x      = XW'(n_reg);
    assign j_inc    = {1'b0, j_reg} + 1'b1;
    assign i_inc    = {1'b0, i_reg} + 1'b1;
    assign k_inc    = {1'b0, k_reg} + 1'b1;
    assign pi_inc   = {1'b0, pi_reg} + 1'b1;
    assign ij_sum   = {1'b0, i_reg} + {1'b0, j_reg};
    assign last_k   = k_inc == {1'b0, n_reg};
    assign acc      = {{L{1'b0}}, wh_reg} + prod_reg + {{L{1'b0}}, mc_reg};
    assign add_t    = {1'b0, a_rd} + {1'b0, b_rd} + {{L{1'b0}}, cy_reg};
    assign sub_y    = {1'b0, b_rd} + {{L{1'b0}}, cy_reg};
    assign r_cur    = cur_reg ? r1_rd : r0_rd;
    assign b_val    = (pi_reg == n_reg) ? '0 : b_rd;
    assign s_val    = {r_cur[L-2:0], sh_reg};
    assign dd       = {1'b0, s_val} - {1'b0, b_val} - {{L{1'b0}}, dbw_reg};
    assign q_bit    = !dbw_reg;
    assign q_new    = {q_reg[L-2:0], q_bit};

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;   k_next = k_reg;   i_next = i_reg;
        j_next = j_reg;   pi_next = pi_reg; op_next = op_reg;
        ovf_next = ovf_reg;  zdiv_next = zdiv_reg;  cw_next = cw_reg;
        cy_next = cy_reg;    mc_next = mc_reg;      wh_next = wh_reg;
        prod_next = prod_reg; li_next = li_reg;     bi_next = bi_reg;
        sh_next = sh_reg;    dbw_next = dbw_reg;    cur_next = cur_reg;
        q_next = q_reg;      dv_next = dv_reg;
        ov_next = ov_reg && out_stall;
        lo_next = lo_reg; hi_next = hi_reg; cf_next = cf_reg;
        zd_next = zd_reg; tl_next = tl_reg; fr_next = fr_reg;
        pop = 1'b0;
        a_ra = '0; b_ra = '0; w_ra0 = '0; w_ra1 = '0; r_ra = '0;
        w_we = 1'b0;  w_wa = '0; w_wd = '0;
        r0_we = 1'b0; r1_we = 1'b0; r_wa = '0; r0_wd = '0; r1_wd = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    pop       = 1'b1;
                    n_next    = NW'(job.cnt);
                    op_next   = job.op;
                    ovf_next  = job.ovf;
                    zdiv_next = job.zdiv;
                    k_next = '0; i_next = '0; j_next = '0; cw_next = '0;
                    cy_next = 1'b0; mc_next = '0; cur_next = 1'b0;
                    if (job.op == mia_pkg::OP_MUL
                        || (job.op == mia_pkg::OP_DIV && !job.zdiv))
                    begin
                        state_next = S_CLR;
                    end
                    else
                    begin
                        state_next = S_ORD;
                    end
                end
            end
            S_CLR:
            begin
                w_we = 1'b1;
                w_wa = cw_reg;
                r_wa = RA'(cw_reg);
                if (cw_x <= n_x)
                begin
                    r0_we = 1'b1;
                    r1_we = 1'b1;
                end
                if (cw_x == (n_x << 1) - XW'(1))
                begin
                    if (op_reg == mia_pkg::OP_MUL)
                    begin
                        state_next = S_MRD;
                    end
                    else
                    begin
                        li_next    = AW'(n_reg - 1'b1);
                        bi_next    = BW'(LIMB_BITS - 1);
                        state_next = S_DA;
                    end
                end
                else
                begin
                    cw_next = cw_reg + 1'b1;
                end
            end
            S_MRD:
            begin
                a_ra  = AW'(i_reg);
                b_ra  = AW'(j_reg);
                w_ra0 = WA'(ij_sum);
                state_next = S_MMUL;
            end
            S_MMUL:
            begin
                prod_next  = a_rd * b_rd;
                wh_next    = w_rd0;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                w_we    = 1'b1;
                w_wa    = WA'(ij_sum);
                w_wd    = acc[L-1:0];
                mc_next = acc[2*L-1:L];
                if (j_inc == {1'b0, n_reg})
                begin
                    state_next = S_MTOP;
                end
                else
                begin
                    j_next     = NW'(j_inc);
                    state_next = S_MRD;
                end
            end
            S_MTOP:
            begin
                // Top carry of row i lands on limb i + n.
                w_we    = 1'b1;
                w_wa    = WA'({1'b0, i_reg} + {1'b0, n_reg});
                w_wd    = mc_reg;
                mc_next = '0;
                j_next  = '0;
                if (i_inc == {1'b0, n_reg})
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    i_next     = NW'(i_inc);
                    state_next = S_MRD;
                end
            end
            S_DA:
            begin
                a_ra       = li_reg;
                state_next = S_DAL;
            end
            S_DAL:
            begin
                dv_next    = a_rd;
                state_next = S_DP;
            end
            S_DP:
            begin
                b_ra       = '0;
                r_ra       = '0;
                pi_next    = '0;
                sh_next    = dv_reg[bi_reg];
                dbw_next   = 1'b0;
                state_next = S_DL;
            end
            S_DL:
            begin
                // Shift the partial remainder by one bit and form the trial
                // difference in the other bank in the same pass.
                b_ra  = AW'(pi_inc);
                r_ra  = RA'(pi_inc);
                r_wa  = RA'(pi_reg);
                r0_we = 1'b1;
                r1_we = 1'b1;
                r0_wd = cur_reg ? dd[L-1:0] : s_val;
                r1_wd = cur_reg ? s_val : dd[L-1:0];
                sh_next  = r_cur[L-1];
                dbw_next = dd[L];
                pi_next  = NW'(pi_inc);
                if (pi_reg == n_reg)
                begin
                    state_next = S_DE;
                end
            end
            S_DE:
            begin
                if (q_bit)
                begin
                    cur_next = !cur_reg;
                end
                q_next = q_new;
                if (bi_reg == '0)
                begin
                    w_we = 1'b1;
                    w_wa = WA'(li_reg);
                    w_wd = q_new;
                    if (li_reg == '0)
                    begin
                        k_next     = '0;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        li_next    = li_reg - 1'b1;
                        bi_next    = BW'(LIMB_BITS - 1);
                        state_next = S_DA;
                    end
                end
                else
                begin
                    bi_next    = bi_reg - 1'b1;
                    state_next = S_DP;
                end
            end
            S_ORD:
            begin
                a_ra  = AW'(k_reg);
                b_ra  = AW'(k_reg);
                w_ra0 = (op_reg == mia_pkg::OP_MUL) ? WA'({k_reg, 1'b0}) : WA'(k_reg);
                w_ra1 = WA'({k_reg, 1'b1});
                r_ra  = RA'(k_reg);
                if (out_free)
                begin
                    state_next = S_OWR;
                end
            end
            S_OWR:
            begin
                ov_next = 1'b1;
                lo_next = '0;
                hi_next = '0;
                cf_next = 1'b0;
                zd_next = zdiv_reg;
                tl_next = ovf_reg;
                fr_next = last_k;
                unique case (op_reg)
                    mia_pkg::OP_ADD:
                    begin
                        lo_next = OW'(add_t[L-1:0]);
                        cy_next = add_t[L];
                        cf_next = last_k && add_t[L];
                    end
                    mia_pkg::OP_SUB:
                    begin
                        lo_next = OW'(a_rd - sub_y[L-1:0]);
                        cy_next = {1'b0, a_rd} < sub_y;
                        cf_next = last_k && ({1'b0, a_rd} < sub_y);
                    end
                    mia_pkg::OP_MUL:
                    begin
                        lo_next = OW'(w_rd0);
                        hi_next = OW'(w_rd1);
                    end
                    mia_pkg::OP_DIV:
                    begin
                        if (!zdiv_reg)
                        begin
                            lo_next = OW'(w_rd0);
                            hi_next = OW'(cur_reg ? r1_rd : r0_rd);
                        end
                    end
                    default:
                    begin
                        lo_next = '0;
                    end
                endcase
                k_next     = NW'(k_inc);
                state_next = last_k ? S_IDLE : S_ORD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (opw.we)
        begin
            a_mem[opw.addr[AW-1:0]] <= opw.a[L-1:0];
            b_mem[opw.addr[AW-1:0]] <= opw.b[L-1:0];
        end
        if (w_we)
        begin
            w_mem[w_wa] <= w_wd;
        end
        if (r0_we)
        begin
            r0_mem[r_wa] <= r0_wd;
        end
        if (r1_we)
        begin
            r1_mem[r_wa] <= r1_wd;
        end
        a_rd  <= a_mem[a_ra];
        b_rd  <= b_mem[b_ra];
        w_rd0 <= w_mem[w_ra0];
        w_rd1 <= w_mem[w_ra1];
        r0_rd <= r0_mem[r_ra];
        r1_rd <= r1_mem[r_ra];
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;   k_reg <= k_next;   i_reg <= i_next;
        j_reg <= j_next;   pi_reg <= pi_next; op_reg <= op_next;
        ovf_reg <= ovf_next;  zdiv_reg <= zdiv_next;  cw_reg <= cw_next;
        cy_reg <= cy_next;    mc_reg <= mc_next;      wh_reg <= wh_next;
        prod_reg <= prod_next; li_reg <= li_next;     bi_reg <= bi_next;
        sh_reg <= sh_next;    dbw_reg <= dbw_next;    cur_reg <= cur_next;
        q_reg <= q_next;      dv_reg <= dv_next;
        lo_reg <= lo_next; hi_reg <= hi_next; cf_reg <= cf_next;
        zd_reg <= zd_next; tl_reg <= tl_next; fr_reg <= fr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid    = ov_reg;
    assign low_word     = lo_reg;
    assign high_word    = hi_reg;
    assign carry_flag   = cf_reg;
    assign zero_divisor = zd_reg;
    assign too_long     = tl_reg;
    assign final_result = fr_reg;
endmodule
`default_nettype wire

// File: rtl/multiword_integer_alu_top.sv
// Top level of the multiword integer ALU: front end, job queue and execution unit.
//
// Usage: operands arrive on the input channel as limb pairs (a_limb, b_limb),
// least significant first, one pair per transfer; last_limb marks the most
// significant pair and starts the run. Up to MAX_LIMBS pairs are stored; later
// pairs are dropped and too_long is raised on every result of that run. The
// operation register (cfg_wr_en / cfg_wr_data) selects add, subtract,
// multiply or divide and is sampled at the transfer that carries last_limb.
// A run of n stored pairs yields n result transfers, least significant limb first,
// with final_result on the last one.
// Input pairs are taken back to back until the input channel stalls. Add and
// subtract go straight to the result steps. Multiply uses one shared multiplier,
// with three steps per partial product (read, multiply, accumulate) and one per
// row for its top carry. Divide is restoring division, one quotient bit per pass
// over n+1 remainder limbs, with a read and a load step per limb to fetch the
// dividend limb. Multiply, and divide with a nonzero divisor, start with a sweep
// over the 2n work memory limbs that clears them; every result is then read
// (S_ORD) and registered into the output (S_OWR). The input channel stalls from
// the last pair until the execution unit has issued the final result.
// Reset clears the sequencer state, the output valid flag, the queue, the front
// end counters and the operation register; operand memory contents are not
// cleared. When the receiver stalls, the output register holds its result and
// the execution unit waits before issuing the next one.
`default_nettype none
module multiword_integer_alu_top #(
    parameter int MAX_LIMBS = 64,
    parameter int LIMB_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] a_limb,
    input  wire logic [31:0] b_limb,
    input  wire logic        last_limb,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      low_word,
    output logic [31:0]      high_word,
    output logic             carry_flag,
    output logic             zero_divisor,
    output logic             too_long,
    output logic             final_result
);
    mia_pkg::job_t push_job, pop_job;
    mia_pkg::opw_t opw;
    logic          push, pop, q_nonempty, back_busy, hold;

    // The operand store is single-buffered, so loading pauses while a run is
    // queued or being executed.
    assign hold = q_nonempty || back_busy;

    mia_front #(
        .MAX_LIMBS (MAX_LIMBS),
        .LIMB_BITS (LIMB_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_limb      (a_limb),
        .b_limb      (b_limb),
        .last_limb   (last_limb),
        .hold        (hold),
        .push        (push),
        .job         (push_job),
        .opw         (opw)
    );

    mia_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (push_job),
        .pop      (pop),
        .dout     (pop_job),
        .nonempty (q_nonempty)
    );

    mia_back #(
        .MAX_LIMBS (MAX_LIMBS),
        .LIMB_BITS (LIMB_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_nonempty),
        .job          (pop_job),
        .pop          (pop),
        .busy         (back_busy),
        .opw          (opw),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .low_word     (low_word),
        .high_word    (high_word),
        .carry_flag   (carry_flag),
        .zero_divisor (zero_divisor),
        .too_long     (too_long),
        .final_result (final_result)
    );
endmodule
`default_nettype wire

// File: rtl/mia_checker.sv
// Port-level checker for the multiword integer ALU and its bind statement.
`default_nettype none
module mia_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        last_limb,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] low_word,
    input wire logic [31:0] high_word,
    input wire logic        carry_flag,
    input wire logic        zero_divisor,
    input wire logic        final_result
);
    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(low_word) && $stable(high_word)
            && $stable(final_result))
    else $error("stalled result changed");

    // Carry or borrow is reported only on the last result of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && carry_flag |-> final_result)
    else $error("carry flag on a non-final result");

    // A zero divisor run delivers zero words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_divisor |-> low_word == 32'd0 && high_word == 32'd0)
    else $error("nonzero words with zero divisor");

    // The transfer of the last pair starts a run, which stalls the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_limb |=> in_stall)
    else $error("input not stalled after last pair");
endmodule

bind multiword_integer_alu_top mia_checker u_mia_checker (.*);
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the multiword integer ALU with a scoreboard class.
`timescale 1ns / 100ps
module tb_top;

    localparam int MAX_LIMBS  = 64;
    localparam int OPND_W     = MAX_LIMBS * mia_pkg::WORD_W;
    localparam int RUN_ITEMS  = 350;
    localparam int CYCLE_CAP  = 4000000;

    // One result of a run as the block should present it.
    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        cy;
        logic        zd;
        logic        tl;
        logic        fin;
    } limb_res_t;

    // The scoreboard mirrors the operand stores and the operation register.
    // Operands are kept as wide vectors so that each operation is a single
    // arithmetic expression over the n loaded limbs.
    class alu_scoreboard;
        mia_pkg::op_t        op;
        int unsigned         loaded;
        bit                  ovf;
        bit [OPND_W-1:0]     opa;
        bit [OPND_W-1:0]     opb;
        bit [OPND_W:0]       wsum;
        bit [2*OPND_W-1:0]   wprod;
        bit [OPND_W-1:0]     quo;
        bit [OPND_W-1:0]     rem;
        limb_res_t           pending[$];
        int                  errors;

        function new();
            op = mia_pkg::OP_ADD;
            loaded = 0;
            ovf = 0;
            opa = '0;
            opb = '0;
            errors = 0;
        endfunction

        function void note_pair(logic [31:0] a, logic [31:0] b, logic last);
            limb_res_t r;
            bit        cy;
            bit        zd;
            if (loaded < MAX_LIMBS) begin
                opa[loaded*mia_pkg::WORD_W +: mia_pkg::WORD_W] = a;
                opb[loaded*mia_pkg::WORD_W +: mia_pkg::WORD_W] = b;
                loaded++;
            end else begin
                ovf = 1;
            end
            if (!last)
                return;
            cy = 0;
            zd = 0;
            case (op)
                mia_pkg::OP_ADD: begin
                    wsum = {1'b0, opa} + {1'b0, opb};
                    cy = wsum[loaded*mia_pkg::WORD_W];
                end
                mia_pkg::OP_SUB: begin
                    wsum = {1'b0, opa - opb};
                    cy = (opa < opb);
                end
                mia_pkg::OP_MUL: wprod = opa * opb;
                default: begin
                    zd = (opb == '0);
                    if (!zd) begin
                        quo = opa / opb;
                        rem = opa % opb;
                    end
                end
            endcase
            for (int k = 0; k < loaded; k++) begin
                r = '0;
                r.fin = (k == loaded - 1);
                r.tl = ovf;
                r.zd = zd;
                if (op == mia_pkg::OP_ADD || op == mia_pkg::OP_SUB) begin
                    r.lo = wsum[k*mia_pkg::WORD_W +: mia_pkg::WORD_W];
                    r.cy = r.fin ? cy : 1'b0;
                end else if (op == mia_pkg::OP_MUL) begin
                    r.lo = wprod[2*k*mia_pkg::WORD_W +: mia_pkg::WORD_W];
                    r.hi = wprod[(2*k+1)*mia_pkg::WORD_W +: mia_pkg::WORD_W];
                end else if (!zd) begin
                    r.lo = quo[k*mia_pkg::WORD_W +: mia_pkg::WORD_W];
                    r.hi = rem[k*mia_pkg::WORD_W +: mia_pkg::WORD_W];
                end
                pending.push_back(r);
            end
            // A run only sees limbs that it loaded itself.
            opa = '0;
            opb = '0;
            loaded = 0;
            ovf = 0;
        endfunction

        function void check_result(limb_res_t got);
            limb_res_t want;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected: %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.lo !== want.lo) begin
                $display("%0t: low_word expected %h got %h", $time, want.lo, got.lo);
                errors++;
            end
            if (got.hi !== want.hi) begin
                $display("%0t: high_word expected %h got %h", $time, want.hi, got.hi);
                errors++;
            end
            if (got.cy !== want.cy) begin
                $display("%0t: carry_flag expected %b got %b", $time, want.cy, got.cy);
                errors++;
            end
            if (got.zd !== want.zd) begin
                $display("%0t: zero_divisor expected %b got %b", $time, want.zd, got.zd);
                errors++;
            end
            if (got.tl !== want.tl) begin
                $display("%0t: too_long expected %b got %b", $time, want.tl, got.tl);
                errors++;
            end
            if (got.fin !== want.fin) begin
                $display("%0t: final_result expected %b got %b", $time, want.fin, got.fin);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_wr_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] a_limb = '0;
    logic [31:0] b_limb = '0;
    logic        last_limb = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [31:0] low_word;
    logic [31:0] high_word;
    logic        carry_flag;
    logic        zero_divisor;
    logic        too_long;
    logic        final_result;

    alu_scoreboard sb = new();
    int            cycles = 0;
    int            items_sent = 0;
    bit            calm = 0;    // when set, neither side inserts gaps

    multiword_integer_alu_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_limb      (a_limb),
        .b_limb      (b_limb),
        .last_limb   (last_limb),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .low_word    (low_word),
        .high_word   (high_word),
        .carry_flag  (carry_flag),
        .zero_divisor(zero_divisor),
        .too_long    (too_long),
        .final_result(final_result)
    );

    // Clock and the run-time guard. The cap is far above the slowest run of the mix
    // below, including up to two full-width mul or div runs under heavy stalls.
    initial begin
        forever begin
            #5 clk = ~clk;
            if (clk) begin
                cycles++;
                if (cycles > CYCLE_CAP) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Limb values biased toward the corners so that carries and borrows
    // ripple across many limbs.
    function automatic logic [31:0] pick_limb();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // One transfer on the input channel. Valid stays up across back-to-back
    // transfers; it is lowered only when a gap follows or the bench waits for idle.
    task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last);
        int gap;
        in_valid  <= 1'b1;
        a_limb    <= a;
        b_limb    <= b;
        last_limb <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_pair(a, b, last);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every expected result has come back, then lets the clock run
    // on so that the block is surely idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Writes the operation register; the block is idle when this is called.
    task automatic set_operation(mia_pkg::op_t op);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= op;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.op = op;
    endtask

    // A run of n pairs. For division the divisor is often shorter than the
    // dividend, and sometimes zero altogether.
    task automatic send_run(int n, mia_pkg::op_t op);
        int      dlen;
        logic [31:0] b;
        dlen = n;
        if (op == mia_pkg::OP_DIV) begin
            case ($urandom_range(0, 5))
                0: dlen = 0;
                1, 2: dlen = $urandom_range(1, n);
                default: dlen = n;
            endcase
        end
        for (int k = 0; k < n; k++) begin
            b = (k < dlen) ? pick_limb() : 32'h0;
            send_pair(pick_limb(), b, k == n - 1);
        end
    endtask

    // Result side: check at every accepted transfer and draw new stalls.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result({low_word, high_word, carry_flag, zero_divisor,
                                 too_long, final_result});
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Stimulus.
    initial begin
        mia_pkg::op_t op;
        int  n;
        int  r;
        int  big_runs;
        big_runs = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part. Add: carry rippling out of the top limb, and zeros.
        set_operation(mia_pkg::OP_ADD);
        send_pair(32'hFFFF_FFFF, 32'h1, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'h0, 1'b1);
        send_pair(32'h0, 32'h0, 1'b1);
        wait_idle();
        // Subtract: A below B wraps and borrows; equal operands give zero.
        set_operation(mia_pkg::OP_SUB);
        send_pair(32'h0, 32'h1, 1'b0);
        send_pair(32'h0, 32'h0, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        wait_idle();
        // Multiply: largest operands and a zero factor.
        set_operation(mia_pkg::OP_MUL);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'h0, 32'hDEAD_BEEF, 1'b1);
        wait_idle();
        // Divide: zero divisor, divide by one, dividend below divisor,
        // and a short divisor under a three-limb dividend.
        set_operation(mia_pkg::OP_DIV);
        send_pair(32'h1234_5678, 32'h0, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'h0, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'h1, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'h0, 1'b1);
        send_pair(32'h5, 32'h7, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'h8000_0001, 1'b0);
        send_pair(32'h0, 32'h3, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'h0, 1'b1);
        wait_idle();

        // Random part: phases of one operation each, mostly small runs,
        // some medium, now and then full width or beyond it.
        while (items_sent < RUN_ITEMS) begin
            op = mia_pkg::op_t'($urandom_range(0, 3));
            calm = ($urandom_range(0, 3) == 0);
            set_operation(op);
            repeat ($urandom_range(2, 6)) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    n = $urandom_range(1, 4);
                else if (r < 88)
                    n = $urandom_range(5, 12);
                else if (r < 96 && (op == mia_pkg::OP_ADD || op == mia_pkg::OP_SUB))
                    n = $urandom_range(13, 40);
                else if (op == mia_pkg::OP_ADD || op == mia_pkg::OP_SUB)
                    n = $urandom_range(MAX_LIMBS, MAX_LIMBS + 4);
                else if (big_runs < 2) begin
                    n = MAX_LIMBS;
                    big_runs++;
                end else
                    n = $urandom_range(13, 16);
                send_run(n, op);
            end
            wait_idle();
        end
        calm = 0;

        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
